// ===== src/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/bctd_pkg.sv =====
// ----------------------------------------------------------------------------
// bctd_pkg
// Types, format codes and palette helpers for the texture block decoder.
// ----------------------------------------------------------------------------
package bctd_pkg;

	typedef enum logic [2:0] {
		FMT_DXT1  = 3'd0,
		FMT_DXT3  = 3'd1,
		FMT_DXT5  = 3'd2,
		FMT_DXT5A = 3'd3,
		FMT_DXT3A = 3'd4,
		FMT_CTX1  = 3'd5,
		FMT_DXN   = 3'd6,
		FMT_FILL  = 3'd7
	} fmt_t;

	localparam logic [7:0] FILL_VALUE = 8'd128;
	localparam logic [7:0] OPAQUE     = 8'd255;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
	} rgba_t;

	// Per-block palettes held while the block's pixels stream out.
	typedef struct packed {
		fmt_t        fmt;
		rgba_t [3:0] cpal;
		chan_t [7:0] apal;
		chan_t [7:0] gpal;
		logic [31:0] cidx;
		logic [47:0] aidx;
		logic [47:0] gidx;
		logic [63:0] eidx;
	} pal_t;

	// Divide by 3 for values below 768: (x * 683) >> 11 is exact there.
	function automatic chan_t div3(input logic [9:0] x);
		logic [19:0] m;
		m = {10'd0, x} * 20'd683;
		return m[18:11];
	endfunction

	// Divide by 7 for values below 1792: (x * 2341) >> 14 is exact there.
	function automatic chan_t div7(input logic [10:0] x);
		logic [22:0] m;
		m = {12'd0, x} * 23'd2341;
		return m[21:14];
	endfunction

	// Divide by 5 for values below 1280: (x * 3277) >> 14 is exact there.
	function automatic chan_t div5(input logic [10:0] x);
		logic [22:0] m;
		m = {12'd0, x} * 23'd3277;
		return m[21:14];
	endfunction

	function automatic chan_t mix3(input chan_t p, input chan_t q);
		return div3({1'b0, p, 1'b0} + {2'b0, q} + 10'd1);
	endfunction

endpackage

// ===== src/bctd_if.sv =====
// ----------------------------------------------------------------------------
// bctd_block_if / bctd_pixel_if
// Valid/ready channels for compressed blocks and decoded pixels.
// ----------------------------------------------------------------------------
interface bctd_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	modport source (output valid, block_low, block_high, input ready);
	modport sink (input valid, block_low, block_high, output ready);
endinterface

interface bctd_pixel_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_pixel;
	modport source (output valid, pixel_index, red, green, blue, alpha, last_pixel,
		input ready);
	modport sink (input valid, pixel_index, red, green, blue, alpha, last_pixel,
		output ready);
endinterface

// ===== src/block_compressed_texture_decoder.sv =====
// ----------------------------------------------------------------------------
// block_compressed_texture_decoder
// Decodes DXT/BC style 4x4 blocks into sixteen RGBA8 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   blk carries one compressed block per beat (block_low = bytes 0..7,
//   block_high = bytes 8..15). pix returns sixteen pixel beats per block in
//   row-major order, last_pixel set on the sixteenth.
//   The user writes format_mode through cfg_we/cfg_data only while idle; the block does not enforce it.
// The path from block accept to first pixel beat runs through stage one
//   (loaded at the accept edge), stages two and three, the pixel walker
//   register and the output register.
// Throughput: one pixel per cycle when pix does not stall, set by the single
//   pixel output port. The palette pipeline takes the next block while the
//   current one streams, so blocks follow back to back.
// Reset clears all valid bits and sets format_mode to DXT1.
// A stall on pix holds the current pixel beat; the palette stages fill and
// then drop blk.ready; nothing is lost or repeated.
module block_compressed_texture_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_data,
	bctd_block_if.sink   blk,
	bctd_pixel_if.source pix
);
	bctd_pkg::fmt_t fmt_q;
	logic           pv;
	logic           pr;
	bctd_pkg::pal_t pal;

	// hold format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= bctd_pkg::FMT_DXT1;
		end else if (cfg_we) begin
			fmt_q <= bctd_pkg::fmt_t'(cfg_data);
		end
	end

	// palettes per block
	bctd_palette u_pal (
		.clk(clk), .arst_n(arst_n),
		.in_valid(blk.valid), .in_ready(blk.ready),
		.fmt(fmt_q), .lo(blk.block_low), .hi(blk.block_high),
		.out_valid(pv), .out_ready(pr), .out_pal(pal)
	);

	// pixel walk and output register
	bctd_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pv), .in_ready(pr), .in_pal(pal),
		.pix(pix)
	);
endmodule

// ===== src/bctd_palette.sv =====
// ----------------------------------------------------------------------------
// bctd_palette
// Three-stage pipeline building color and alpha palettes for one block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bctd_palette (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bctd_pkg::fmt_t     fmt,
	input  logic [63:0]        lo,
	input  logic [63:0]        hi,
	output logic               out_valid,
	input  logic               out_ready,
	output bctd_pkg::pal_t     out_pal
);
	// stage 1: endpoint expansion
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	bctd_pkg::fmt_t fmt_s1, fmt_s2;
	logic [63:0] lo_s1, hi_s1, lo_s2, hi_s2;
	bctd_pkg::rgba_t c0_s1, c1_s1;
	logic punch_s1;
	bctd_pkg::rgba_t c0_s2, c1_s2;
	logic punch_s2;
	logic [10:0] amul_s2 [0:5];
	logic [10:0] gmul_s2 [0:5];
	logic agt_s2, ggt_s2;
	bctd_pkg::pal_t pal_s3;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	function automatic bctd_pkg::rgba_t exp565(input logic [15:0] c);
		bctd_pkg::rgba_t x;
		x.r = {c[15:11], c[15:13]};
		x.g = {c[10:5], c[10:9]};
		x.b = {c[4:0], c[4:2]};
		x.a = bctd_pkg::OPAQUE;
		return x;
	endfunction

	logic [63:0] csrc;
	always_comb begin
		csrc = (fmt == bctd_pkg::FMT_DXT1) ? lo : hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			fmt_s1 <= fmt;
			lo_s1 <= lo;
			hi_s1 <= hi;
			if (fmt == bctd_pkg::FMT_CTX1) begin
				c0_s1 <= {lo[7:0], lo[15:8], 8'd0, bctd_pkg::OPAQUE};
				c1_s1 <= {lo[23:16], lo[31:24], 8'd0, bctd_pkg::OPAQUE};
			end else begin
				c0_s1 <= exp565(csrc[15:0]);
				c1_s1 <= exp565(csrc[31:16]);
			end
			punch_s1 <= (fmt == bctd_pkg::FMT_DXT1) && !(csrc[15:0] > csrc[31:16]);
		end
	end

	// stage 2: alpha weighted sums, one multiply-add per entry
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			fmt_s2 <= fmt_s1;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			c0_s2 <= c0_s1;
			c1_s2 <= c1_s1;
			punch_s2 <= punch_s1;
			agt_s2 <= lo_s1[7:0] > lo_s1[15:8];
			ggt_s2 <= hi_s1[7:0] > hi_s1[15:8];
			for (int i = 0; i < 6; i++) begin
				if (lo_s1[7:0] > lo_s1[15:8])
					amul_s2[i] <= 11'(3'(6 - i) * lo_s1[7:0]) + 11'(3'(i + 1) * lo_s1[15:8])
						+ 11'd3;
				else
					amul_s2[i] <= 11'(3'(4 - i) * lo_s1[7:0]) + 11'(3'(i + 1) * lo_s1[15:8])
						+ 11'd2;
				if (hi_s1[7:0] > hi_s1[15:8])
					gmul_s2[i] <= 11'(3'(6 - i) * hi_s1[7:0]) + 11'(3'(i + 1) * hi_s1[15:8])
						+ 11'd3;
				else
					gmul_s2[i] <= 11'(3'(4 - i) * hi_s1[7:0]) + 11'(3'(i + 1) * hi_s1[15:8])
						+ 11'd2;
			end
		end
	end

	// stage 3: divide and finish palettes
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			pal_s3.fmt <= fmt_s2;
			pal_s3.cpal[0] <= c0_s2;
			pal_s3.cpal[1] <= c1_s2;
			if (punch_s2) begin
				pal_s3.cpal[2] <= {8'((9'(c0_s2.r) + 9'(c1_s2.r)) >> 1),
					8'((9'(c0_s2.g) + 9'(c1_s2.g)) >> 1),
					8'((9'(c0_s2.b) + 9'(c1_s2.b)) >> 1), bctd_pkg::OPAQUE};
				pal_s3.cpal[3] <= '0;
			end else begin
				pal_s3.cpal[2] <= {bctd_pkg::mix3(c0_s2.r, c1_s2.r),
					bctd_pkg::mix3(c0_s2.g, c1_s2.g),
					bctd_pkg::mix3(c0_s2.b, c1_s2.b), c0_s2.a};
				pal_s3.cpal[3] <= {bctd_pkg::mix3(c1_s2.r, c0_s2.r),
					bctd_pkg::mix3(c1_s2.g, c0_s2.g),
					bctd_pkg::mix3(c1_s2.b, c0_s2.b), c0_s2.a};
			end
			pal_s3.apal[0] <= lo_s2[7:0];
			pal_s3.apal[1] <= lo_s2[15:8];
			pal_s3.gpal[0] <= hi_s2[7:0];
			pal_s3.gpal[1] <= hi_s2[15:8];
			for (int i = 0; i < 6; i++) begin
				if (agt_s2) pal_s3.apal[i + 2] <= bctd_pkg::div7(amul_s2[i]);
				else if (i < 4) pal_s3.apal[i + 2] <= bctd_pkg::div5(amul_s2[i]);
				else pal_s3.apal[i + 2] <= (i == 4) ? 8'd0 : bctd_pkg::OPAQUE;
				if (ggt_s2) pal_s3.gpal[i + 2] <= bctd_pkg::div7(gmul_s2[i]);
				else if (i < 4) pal_s3.gpal[i + 2] <= bctd_pkg::div5(gmul_s2[i]);
				else pal_s3.gpal[i + 2] <= (i == 4) ? 8'd0 : bctd_pkg::OPAQUE;
			end
			pal_s3.cidx <= (fmt_s2 == bctd_pkg::FMT_DXT1 || fmt_s2 == bctd_pkg::FMT_CTX1)
				? lo_s2[63:32] : hi_s2[63:32];
			pal_s3.aidx <= lo_s2[63:16];
			pal_s3.gidx <= hi_s2[63:16];
			pal_s3.eidx <= lo_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_pal = pal_s3;

	`ASSERT_NEXT(a_hold_s3, clk, arst_n, v_s3 && !out_ready, v_s3 && $stable(pal_s3), "s3 lost")
	`ASSERT_NEXT(a_adv_s2, clk, arst_n, v_s2 && en3, v_s3, "s2 beat dropped")
	`ASSERT_CLK(a_ready, clk, arst_n, !in_ready || !v_s1 || en2, "ready while s1 blocked")
endmodule

// ===== src/bctd_emit.sv =====
// ----------------------------------------------------------------------------
// bctd_emit
// Walks the sixteen pixels of a palette set and drives registered output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module bctd_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bctd_pkg::pal_t in_pal,
	bctd_pixel_if.source   pix
);
	bctd_pkg::pal_t pal_q;
	logic           busy_q;
	logic [3:0]     cnt_q;
	logic           ov_q;
	logic           pix_en;
	bctd_pkg::rgba_t px;
	logic [1:0] ci;
	logic [2:0] ai, gi;
	logic [3:0] ev;
	logic [7:0] ex;

	assign pix_en = !ov_q || pix.ready;
	assign in_ready = !busy_q || (pix_en && cnt_q == 4'd15);

	always_comb begin
		ci = pal_q.cidx[2 * cnt_q +: 2];
		ai = pal_q.aidx[3 * cnt_q +: 3];
		gi = pal_q.gidx[3 * cnt_q +: 3];
		ev = pal_q.eidx[4 * cnt_q +: 4];
		ex = {ev, ev};
		unique case (pal_q.fmt)
			bctd_pkg::FMT_DXT1, bctd_pkg::FMT_CTX1: px = pal_q.cpal[ci];
			bctd_pkg::FMT_DXT3: px = {pal_q.cpal[ci][31:8], ex};
			bctd_pkg::FMT_DXT5: px = {pal_q.cpal[ci][31:8], pal_q.apal[ai]};
			bctd_pkg::FMT_DXT5A: px = {pal_q.apal[ai], pal_q.apal[ai], pal_q.apal[ai],
				bctd_pkg::OPAQUE};
			bctd_pkg::FMT_DXT3A: px = {ex, ex, ex, bctd_pkg::OPAQUE};
			bctd_pkg::FMT_DXN: px = {pal_q.apal[ai], pal_q.gpal[gi], 8'd0, bctd_pkg::OPAQUE};
			default: px = {4{bctd_pkg::FILL_VALUE}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 4'd0;
			ov_q <= 1'b0;
		end else begin
			if (pix_en) ov_q <= busy_q;
			if (in_ready) begin
				busy_q <= in_valid;
				cnt_q <= 4'd0;
			end else if (busy_q && pix_en) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) pal_q <= in_pal;
		if (pix_en && busy_q) begin
			pix.pixel_index <= cnt_q;
			pix.red <= px.r;
			pix.green <= px.g;
			pix.blue <= px.b;
			pix.alpha <= px.a;
			pix.last_pixel <= (cnt_q == 4'd15);
		end
	end

	assign pix.valid = ov_q;

	`ASSERT_NEXT(a_hold, clk, arst_n, ov_q && !pix.ready, ov_q && $stable(pix.pixel_index),
		"pixel beat changed under stall")
	`ASSERT_NEXT(a_step, clk, arst_n, busy_q && pix_en && cnt_q != 4'd15,
		busy_q && cnt_q == $past(cnt_q) + 4'd1, "pixel skipped")
	`ASSERT_CLK(a_last, clk, arst_n, !ov_q || pix.last_pixel == (pix.pixel_index == 4'd15),
		"last mark wrong")
endmodule

// ===== bench/bctd_test_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bctd test channels
// Record types for the bench; the channel interfaces come from the RTL.
// ----------------------------------------------------------------------------
// The channels themselves come from the RTL interface file; this file only
// holds a small helper package for the bench's pixel and block records.
package bctd_test_pkg;
	import bctd_pkg::*;

	typedef struct packed {
		logic [3:0] index;
		chan_t      r;
		chan_t      g;
		chan_t      b;
		chan_t      a;
		logic       last;
	} pixel_rec_t;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
	} block_rec_t;
endpackage

// ===== bench/block_compressed_texture_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_compressed_texture_decoder_test
// Drives compressed 4x4 blocks in every format through the decoder, predicts
// the sixteen RGBA pixels of each block and compares them beat by beat.
// ----------------------------------------------------------------------------
module block_compressed_texture_decoder_test;
	import bctd_pkg::*;
	import bctd_test_pkg::*;

	localparam int LATENCY = 4;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_data = 3'd0;

	bctd_block_if blk ();
	bctd_pixel_if pix ();

	block_compressed_texture_decoder u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.blk(blk), .pix(pix)
	);

	always #1 clk = ~clk;

	fmt_t       cur_fmt;
	block_rec_t pending_blocks[$];
	pixel_rec_t expected_pixels[$];
	int         mismatches = 0;
	int         cycles = 0;
	int         long_hold = 0;
	bit         pause_send = 1'b0;
	int         burst_left = 0;
	int         gap_left = 0;

	// ---------------------------------------------------------------- predictor
	function automatic chan_t rep5(logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic chan_t rep6(logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Two-thirds / one-third mix with rounding, as used by colors and CTX1.
	function automatic chan_t third(int p, int q);
		return chan_t'((2 * p + q + 1) / 3);
	endfunction

	// Eight-entry interpolated alpha ramp from bytes 0 and 1 of a half.
	function automatic void alpha_ramp(logic [63:0] h, output chan_t ramp[8]);
		int a0, a1;
		a0 = h[7:0];
		a1 = h[15:8];
		ramp[0] = a0;
		ramp[1] = a1;
		if (a0 > a1) begin
			for (int i = 0; i < 6; i++)
				ramp[i + 2] = chan_t'(((6 - i) * a0 + (i + 1) * a1 + 3) / 7);
		end else begin
			for (int i = 0; i < 4; i++)
				ramp[i + 2] = chan_t'(((4 - i) * a0 + (i + 1) * a1 + 2) / 5);
			ramp[6] = 8'd0;
			ramp[7] = OPAQUE;
		end
	endfunction

	// Four-entry color palette from the two 565 endpoints of a half.
	function automatic void color_table(logic [63:0] h, bit punch, output rgba_t tbl[4]);
		logic [15:0] e0, e1;
		e0 = h[15:0];
		e1 = h[31:16];
		tbl[0] = '{rep5(e0[15:11]), rep6(e0[10:5]), rep5(e0[4:0]), OPAQUE};
		tbl[1] = '{rep5(e1[15:11]), rep6(e1[10:5]), rep5(e1[4:0]), OPAQUE};
		if (e0 > e1 || !punch) begin
			tbl[2] = '{third(tbl[0].r, tbl[1].r), third(tbl[0].g, tbl[1].g),
				third(tbl[0].b, tbl[1].b), OPAQUE};
			tbl[3] = '{third(tbl[1].r, tbl[0].r), third(tbl[1].g, tbl[0].g),
				third(tbl[1].b, tbl[0].b), OPAQUE};
		end else begin
			tbl[2] = '{chan_t'((int'(tbl[0].r) + tbl[1].r) / 2),
				chan_t'((int'(tbl[0].g) + tbl[1].g) / 2),
				chan_t'((int'(tbl[0].b) + tbl[1].b) / 2), OPAQUE};
			tbl[3] = '0;
		end
	endfunction

	// Queue the sixteen pixels one block decodes to under the current format.
	function automatic void predict_block(block_rec_t blkv);
		rgba_t tbl[4];
		chan_t ramp_lo[8], ramp_hi[8];
		rgba_t px;
		pixel_rec_t rec;
		logic [1:0] ci;
		logic [3:0] ev;
		chan_t x0, y0, x1, y1;
		case (cur_fmt)
			FMT_DXT1: color_table(blkv.lo, 1'b1, tbl);
			FMT_DXT3, FMT_DXT5: color_table(blkv.hi, 1'b0, tbl);
			default: ;
		endcase
		alpha_ramp(blkv.lo, ramp_lo);
		alpha_ramp(blkv.hi, ramp_hi);
		x0 = blkv.lo[7:0];
		y0 = blkv.lo[15:8];
		x1 = blkv.lo[23:16];
		y1 = blkv.lo[31:24];
		for (int p = 0; p < 16; p++) begin
			ev = blkv.lo[4 * p +: 4];
			case (cur_fmt)
				FMT_DXT1: px = tbl[blkv.lo[32 + 2 * p +: 2]];
				FMT_DXT3: begin
					px = tbl[blkv.hi[32 + 2 * p +: 2]];
					px.a = {ev, ev};
				end
				FMT_DXT5: begin
					px = tbl[blkv.hi[32 + 2 * p +: 2]];
					px.a = ramp_lo[blkv.lo[16 + 3 * p +: 3]];
				end
				FMT_DXT5A: begin
					px.r = ramp_lo[blkv.lo[16 + 3 * p +: 3]];
					px = '{px.r, px.r, px.r, OPAQUE};
				end
				FMT_DXT3A: px = '{{ev, ev}, {ev, ev}, {ev, ev}, OPAQUE};
				FMT_CTX1: begin
					ci = blkv.lo[32 + 2 * p +: 2];
					case (ci)
						2'd0: px = '{x0, y0, 8'd0, OPAQUE};
						2'd1: px = '{x1, y1, 8'd0, OPAQUE};
						2'd2: px = '{third(x0, x1), third(y0, y1), 8'd0, OPAQUE};
						default: px = '{third(x1, x0), third(y1, y0), 8'd0, OPAQUE};
					endcase
				end
				FMT_DXN: px = '{ramp_lo[blkv.lo[16 + 3 * p +: 3]],
					ramp_hi[blkv.hi[16 + 3 * p +: 3]], 8'd0, OPAQUE};
				default: px = '{FILL_VALUE, FILL_VALUE, FILL_VALUE, FILL_VALUE};
			endcase
			rec = '{4'(p), px.r, px.g, px.b, px.a, p == 15};
			expected_pixels.push_back(rec);
		end
	endfunction

	// ---------------------------------------------------------------- driver
	// Bursts of random length, random gaps; hold the beat until accepted.
	// The offered beat stays at the queue head until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk.valid <= 1'b0;
			blk.block_low <= '0;
			blk.block_high <= '0;
		end else begin
			if (blk.valid && blk.ready) begin
				predict_block('{blk.block_low, blk.block_high});
				void'(pending_blocks.pop_front());
			end
			if ((blk.valid && !blk.ready)) begin
				// hold the offered beat
			end else if (pending_blocks.size() > 0 && !pause_send
					&& (burst_left > 0 || gap_left == 0)) begin
				blk.valid <= 1'b1;
				blk.block_low <= pending_blocks[0].lo;
				blk.block_high <= pending_blocks[0].hi;
				if (burst_left > 0) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(12, 0);
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
				end
			end else begin
				blk.valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// Stall pattern: bursts of random stalls, quiet stretches, and long holds.
	always @(posedge clk or negedge arst_n) begin
		pixel_rec_t got, want;
		if (!arst_n) begin
			pix.ready <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (long_hold > 0) begin
				long_hold <= long_hold - 1;
				pix.ready <= 1'b0;
			end else if ((cycles / 300) % 3 == 0) begin
				pix.ready <= 1'b1;
			end else begin
				pix.ready <= ($urandom_range(3, 0) != 0);
			end
			if (pix.valid && pix.ready) begin
				got = '{pix.pixel_index, pix.red, pix.green, pix.blue, pix.alpha,
					pix.last_pixel};
				if (expected_pixels.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected pixel beat %p", got);
				end else begin
					want = expected_pixels.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("pixel mismatch: expected %p got %p", want, got);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic wait_drained();
		while (pending_blocks.size() != 0 || expected_pixels.size() != 0 || blk.valid)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_format(fmt_t f);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = f;
	endtask

	// Queue one block for the driver.
	task automatic add_block(logic [63:0] lo, logic [63:0] hi);
		pending_blocks.push_back('{lo, hi});
	endtask

	initial begin
		fmt_t f;
		logic [63:0] lo, hi;
		cur_fmt = FMT_DXT1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset format, then field extremes in every format.
		add_block('0, '0);
		add_block('1, '1);
		add_block(64'hE4E4_E4E4_0000_FFFF, '0);  // four-color endpoints
		add_block(64'hE4E4_E4E4_FFFF_0000, '0);  // three-color, transparent entry
		add_block(64'hE4E4_E4E4_1234_1234, '0);  // equal endpoints
		for (int k = 0; k < 8; k++) begin
			set_format(fmt_t'(k));
			add_block(64'hFAC6_88FA_C688_00FF, 64'h0123_4567_89AB_FF00);
			add_block(64'h0123_4567_89AB_FF00, 64'hE4E4_E4E4_0000_FFFF);
		end

		// Random: walk all formats one phase each, then random formats; receiver held off once.
		for (int ph = 0; ph < 16; ph++) begin
			f = (ph < 8) ? fmt_t'(ph) : fmt_t'($urandom_range(7, 0));
			set_format(f);
			if (ph == 3) long_hold <= 400;
			for (int n = 0; n < 10; n++) begin
				lo = rand64();
				hi = rand64();
				case ($urandom_range(5, 0))
					0: lo[15:0] = lo[31:16];
					1: lo[15:8] = lo[7:0];
					2: hi[15:8] = hi[7:0];
					default: ;
				endcase
				add_block(lo, hi);
			end
			if (ph == 8) begin
				// brief sender pause (the wait is always satisfied), then drain all blocks
				pause_send = 1'b1;
				wait (pending_blocks.size() == 0 || 1);
				pause_send = 1'b0;
				wait_drained();
			end
		end

		wait_drained();
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== block_compressed_texture_decoder.f =====
+incdir+src
src/bctd_pkg.sv
src/bctd_if.sv
src/bctd_palette.sv
src/bctd_emit.sv
src/block_compressed_texture_decoder.sv
bench/bctd_test_if.sv
bench/block_compressed_texture_decoder_test.sv
